// File: design/obstacle_steering_trip_controller_assert.svh
// Assertion macros used by the top-level RTL
`ifndef OBSTACLE_STEERING_TRIP_CONTROLLER_ASSERT_SVH
`define OBSTACLE_STEERING_TRIP_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define OSTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OSTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/ostc_pkg.sv
package ostc_pkg;

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // floor(us*17/1000) as a reciprocal multiply
  localparam logic [24:0] ECHO_RECIP = 25'd18253614;
  localparam int unsigned ECHO_SHIFT = 30;
  // floor(pot*255/4095) as a reciprocal multiply
  localparam logic [22:0] POT_RECIP  = 23'd4178957;
  localparam int unsigned POT_SHIFT  = 26;
  // floor(x/90) reciprocal, folded into the steering table
  localparam int unsigned DUTY_RECIP = 46604;
  localparam int unsigned DUTY_SHIFT = 22;

  localparam logic [8:0] DIST_MAX     = 9'd400;
  localparam logic [8:0] ZONE_RANGE   = 9'd200;
  localparam logic [8:0] STEER_MIN_CM = 9'd5;
  localparam logic [7:0] STEER_CENTRE = 8'd90;

  typedef enum logic [1:0] {
    ZONE_CLEAR  = 2'd0,
    ZONE_CENTRE = 2'd1,
    ZONE_LEFT   = 2'd2,
    ZONE_RIGHT  = 2'd3
  } zone_t;

  typedef enum logic [1:0] {
    END_NONE   = 2'd0,
    END_BUTTON = 2'd1,
    END_FALL   = 2'd2
  } trip_end_t;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_FALL_THR   = 2'd1,
    CFG_IMU_EN     = 2'd2,
    CFG_BRAKE_DIST = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [14:0] fall_threshold;
    logic        imu_enabled;
    logic [8:0]  brake_distance_cm;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               start_level;
    logic               node_level;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic [8:0]         dist_left;
    logic [8:0]         dist_centre;
    logic [8:0]         dist_right;
    logic [7:0]         pot_max;
  } item_t;

  typedef struct packed {
    zone_t      zone;
    logic       near;
    logic [7:0] angle;
    logic [7:0] duty;
  } steer_t;

  typedef struct packed {
    logic       trip_on;
    logic [15:0] nodes_seen;
    logic       node_event;
    trip_end_t  trip_end;
    zone_t      zone;
    logic       brake;
    logic [7:0] angle;
    logic [7:0] duty;
  } result_t;

  typedef logic [255:0][6:0]  dev_lut_t;
  typedef logic [255:0][22:0] devk_lut_t;

  function automatic dev_lut_t build_dev_lut();
    dev_lut_t    lut;
    int unsigned c;
    for (int i = 0; i < 256; i++) begin
      c = (i < 5) ? 5 : ((i > 200) ? 200 : i);
      lut[i] = 7'(((200 - c) * 90) / 195);
    end
    return lut;
  endfunction

  function automatic devk_lut_t build_devk_lut();
    devk_lut_t   lut;
    int unsigned c;
    for (int i = 0; i < 256; i++) begin
      c = (i < 5) ? 5 : ((i > 200) ? 200 : i);
      lut[i] = 23'((((200 - c) * 90) / 195) * DUTY_RECIP);
    end
    return lut;
  endfunction

  localparam dev_lut_t  DEV_LUT  = build_dev_lut();
  localparam devk_lut_t DEVK_LUT = build_devk_lut();

endpackage

// File: design/ostc_echo.sv
module ostc_echo (
  input  logic [13:0] echo_us,
  output logic [8:0]  dist_cm
);
  import ostc_pkg::*;

  logic [38:0] prod;
  logic [8:0]  quot;

  assign prod = 39'(echo_us) * 39'(ECHO_RECIP);
  assign quot = prod[ECHO_SHIFT +: 9];

  always_comb begin
    if (echo_us == 14'd0 || quot > DIST_MAX) begin
      dist_cm = DIST_MAX;
    end else begin
      dist_cm = quot;
    end
  end

endmodule

// File: design/ostc_steer.sv
module ostc_steer (
  input  logic [8:0]       dist_left,
  input  logic [8:0]       dist_centre,
  input  logic [8:0]       dist_right,
  input  logic [7:0]       pot_max,
  input  logic [8:0]       brake_distance_cm,
  output ostc_pkg::steer_t steer
);
  import ostc_pkg::*;

  logic        hit_c;
  logic        hit_l;
  logic        hit_r;
  logic [8:0]  d_sel;
  logic [7:0]  c_idx;
  logic [6:0]  dev;
  logic [22:0] devk;
  logic [30:0] duty_prod;

  assign hit_c = dist_centre < ZONE_RANGE;
  assign hit_l = dist_left < ZONE_RANGE;
  assign hit_r = dist_right < ZONE_RANGE;
  assign d_sel = hit_l ? dist_left : dist_right;

  always_comb begin
    if (d_sel < STEER_MIN_CM) begin
      c_idx = STEER_MIN_CM[7:0];
    end else if (d_sel > ZONE_RANGE) begin
      c_idx = ZONE_RANGE[7:0];
    end else begin
      c_idx = d_sel[7:0];
    end
  end

  assign dev       = DEV_LUT[c_idx];
  assign devk      = DEVK_LUT[c_idx];
  assign duty_prod = 31'(devk) * 31'(pot_max);

  always_comb begin
    steer.near  = dist_centre < brake_distance_cm;
    steer.angle = STEER_CENTRE;
    steer.duty  = 8'd0;
    if (hit_c) begin
      steer.zone = ZONE_CENTRE;
    end else if (hit_l) begin
      steer.zone  = ZONE_LEFT;
      steer.angle = STEER_CENTRE + 8'(dev);
      steer.duty  = duty_prod[DUTY_SHIFT +: 8];
    end else if (hit_r) begin
      steer.zone  = ZONE_RIGHT;
      steer.angle = STEER_CENTRE - 8'(dev);
      steer.duty  = duty_prod[DUTY_SHIFT +: 8];
    end else begin
      steer.zone = ZONE_CLEAR;
    end
  end

endmodule

// File: design/ostc_trip.sv
module ostc_trip (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ostc_pkg::cfg_t    cfg,
  input  ostc_pkg::item_t   item,
  input  ostc_pkg::steer_t  steer,
  output ostc_pkg::result_t res
);
  import ostc_pkg::*;

  logic        prev_start_r, prev_start_nxt;
  logic        prev_node_r, prev_node_nxt;
  logic [31:0] start_time_r, start_time_nxt;
  logic [31:0] node_time_r, node_time_nxt;
  logic        trip_r, trip_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  zone_t       zone_r, zone_nxt;
  logic        brake_r, brake_nxt;

  logic [31:0] start_gap;
  logic [31:0] node_gap;
  logic        start_press;
  logic        node_press;
  logic [15:0] abs_x;
  logic [15:0] abs_y;
  logic        fall;
  logic        node_ev;
  trip_end_t   end_code;
  logic [7:0]  angle;
  logic [7:0]  duty;

  assign start_gap   = item.now_ms - start_time_r;
  assign node_gap    = item.now_ms - node_time_r;
  assign start_press = prev_start_r && !item.start_level &&
                       (start_gap > {16'd0, cfg.debounce_ms});
  assign node_press  = prev_node_r && !item.node_level &&
                       (node_gap > {16'd0, cfg.debounce_ms});

  assign abs_x = item.accel_x[15] ? 16'(-item.accel_x) : item.accel_x;
  assign abs_y = item.accel_y[15] ? 16'(-item.accel_y) : item.accel_y;
  assign fall  = cfg.imu_enabled && ((abs_x > {1'b0, cfg.fall_threshold}) ||
                                     (abs_y > {1'b0, cfg.fall_threshold}));

  always_comb begin
    prev_start_nxt = item.start_level;
    prev_node_nxt  = item.node_level;
    start_time_nxt = start_time_r;
    node_time_nxt  = node_time_r;
    trip_nxt       = trip_r;
    cnt_nxt        = cnt_r;
    zone_nxt       = zone_r;
    brake_nxt      = brake_r;
    node_ev        = 1'b0;
    end_code       = END_NONE;
    angle          = STEER_CENTRE;
    duty           = 8'd0;

    if (start_press) begin
      start_time_nxt = item.now_ms;
      if (!trip_r) begin
        trip_nxt = 1'b1;
        cnt_nxt  = 16'd0;
      end else begin
        trip_nxt = 1'b0;
        end_code = END_BUTTON;
      end
      zone_nxt  = ZONE_CLEAR;
      brake_nxt = 1'b0;
    end

    if (trip_nxt) begin
      if (node_press) begin
        node_time_nxt = item.now_ms;
        if (cnt_nxt != 16'hFFFF) begin
          cnt_nxt = 16'(cnt_nxt + 16'd1);
        end
        node_ev = 1'b1;
      end
      if (fall) begin
        trip_nxt  = 1'b0;
        end_code  = END_FALL;
        zone_nxt  = ZONE_CLEAR;
        brake_nxt = 1'b0;
      end else begin
        case (steer.zone)
          ZONE_CENTRE: begin
            // brake is sticky only while the centre zone persists
            if (zone_nxt != ZONE_CENTRE) begin
              brake_nxt = 1'b0;
            end
            zone_nxt = ZONE_CENTRE;
            if (steer.near) begin
              brake_nxt = 1'b1;
            end
          end
          default: begin
            zone_nxt  = steer.zone;
            brake_nxt = 1'b0;
          end
        endcase
        angle = steer.angle;
        duty  = steer.duty;
      end
    end

    res.trip_on    = trip_nxt;
    res.nodes_seen = cnt_nxt;
    res.node_event = node_ev;
    res.trip_end   = end_code;
    res.zone       = zone_nxt;
    res.brake      = brake_nxt;
    res.angle      = angle;
    res.duty       = duty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_start_r <= 1'b1;
      prev_node_r  <= 1'b1;
      start_time_r <= 32'd0;
      node_time_r  <= 32'd0;
      trip_r       <= 1'b0;
      cnt_r        <= 16'd0;
      zone_r       <= ZONE_CLEAR;
      brake_r      <= 1'b0;
    end else if (en) begin
      prev_start_r <= prev_start_nxt;
      prev_node_r  <= prev_node_nxt;
      start_time_r <= start_time_nxt;
      node_time_r  <= node_time_nxt;
      trip_r       <= trip_nxt;
      cnt_r        <= cnt_nxt;
      zone_r       <= zone_nxt;
      brake_r      <= brake_nxt;
    end
  end

endmodule

// File: design/obstacle_steering_trip_controller.sv
// Takes one request per clock while results are taken and returns one result per request:
// the request is held in the input register and its result is then registered in the
// result register until it is taken. Echo widths are converted to centimetres and the
// potentiometer scaled ahead of the input register; button debounce, trip and node state,
// fall check, zone and brake, and the steering lookup with its duty multiply sit between
// the input register and the result register. While a finished result waits to be taken
// the input register can take one more request, after which in_tready stays low until the
// result is taken. Configuration writes take effect on the next edge and should be made
// while no request is in flight.
`include "obstacle_steering_trip_controller_assert.svh"

module obstacle_steering_trip_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // now_ms[31:0], start_level[32], node_level[33], accel_x[49:34], accel_y[65:50],
  // echo_left_us[79:66], echo_center_us[93:80], echo_right_us[107:94], pot_raw[119:108]
  input  logic [ostc_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // trip_on[0], nodes_seen[16:1], node_event[17], trip_end[19:18], zone_out[21:20],
  // brake_out[22], steer_angle[30:23], pwm_duty[38:31], zero[39]
  output logic [ostc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [ostc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ostc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ostc_pkg::*;

  cfg_t        cfg_r;
  item_t       in_item;
  item_t       s1_item_r;
  logic        s1_valid_r, s1_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_r;
  result_t     res;
  steer_t      steer;
  logic        in_fire;
  logic        advance;
  logic [34:0] pot_prod;

  assign in_item.now_ms      = in_tdata[31:0];
  assign in_item.start_level = in_tdata[32];
  assign in_item.node_level  = in_tdata[33];
  assign in_item.accel_x     = in_tdata[49:34];
  assign in_item.accel_y     = in_tdata[65:50];
  assign pot_prod            = 35'(in_tdata[119:108]) * 35'(POT_RECIP);
  assign in_item.pot_max     = pot_prod[POT_SHIFT +: 8];

  ostc_echo u_echo_left (
    .echo_us (in_tdata[79:66]),
    .dist_cm (in_item.dist_left)
  );

  ostc_echo u_echo_centre (
    .echo_us (in_tdata[93:80]),
    .dist_cm (in_item.dist_centre)
  );

  ostc_echo u_echo_right (
    .echo_us (in_tdata[107:94]),
    .dist_cm (in_item.dist_right)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms       <= 16'd300;
      cfg_r.fall_threshold    <= 15'd6683;
      cfg_r.imu_enabled       <= 1'b1;
      cfg_r.brake_distance_cm <= 9'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   cfg_r.debounce_ms       <= cfg_wdata;
        CFG_FALL_THR:   cfg_r.fall_threshold    <= cfg_wdata[14:0];
        CFG_IMU_EN:     cfg_r.imu_enabled       <= cfg_wdata[0];
        CFG_BRAKE_DIST: cfg_r.brake_distance_cm <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  ostc_steer u_steer (
    .dist_left         (s1_item_r.dist_left),
    .dist_centre       (s1_item_r.dist_centre),
    .dist_right        (s1_item_r.dist_right),
    .pot_max           (s1_item_r.pot_max),
    .brake_distance_cm (cfg_r.brake_distance_cm),
    .steer             (steer)
  );

  ostc_trip u_trip (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .cfg   (cfg_r),
    .item  (s1_item_r),
    .steer (steer),
    .res   (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.duty, out_r.angle, out_r.brake, out_r.zone,
                       out_r.trip_end, out_r.node_event, out_r.nodes_seen, out_r.trip_on};

  `OSTC_ASSERT_IMP(a_duty_idle, out_valid_r && !out_r.trip_on, out_r.duty == 8'd0,
                   "duty while trip off")
  `OSTC_ASSERT_IMP(a_end_off, out_valid_r && out_r.trip_end != END_NONE, !out_r.trip_on,
                   "trip end with trip on")
  `OSTC_ASSERT_IMP(a_angle_zone, out_valid_r && out_r.angle != STEER_CENTRE,
                   out_r.zone == ZONE_LEFT || out_r.zone == ZONE_RIGHT,
                   "steering outside side zone")
  `OSTC_ASSERT_NXT(a_stall_hold, s1_valid_r && !advance, s1_valid_r, "held request dropped")

endmodule

// File: sim/tb_obstacle_steering_trip_controller.sv
module tb_obstacle_steering_trip_controller;
  import ostc_pkg::*;

  typedef struct {
    logic [31:0]        now_ms;
    logic               start_level;
    logic               node_level;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic [13:0]        echo_left;
    logic [13:0]        echo_centre;
    logic [13:0]        echo_right;
    logic [11:0]        pot_raw;
  } tick_t;

  typedef struct packed {
    logic        trip_on;
    logic [15:0] nodes_seen;
    logic        node_event;
    trip_end_t   trip_end;
    zone_t       zone;
    logic        brake;
    logic [7:0]  angle;
    logic [7:0]  duty;
  } report_t;

  typedef struct {
    tick_t   t;
    bit      fixed;
    report_t r;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  obstacle_steering_trip_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow registers
  logic [15:0] debounce_lim = 16'd300;
  logic [14:0] fall_lim     = 15'd6683;
  logic        imu_on       = 1'b1;
  logic [8:0]  brake_cm     = 9'd100;

  // shadow trip state
  logic        last_start = 1'b1;
  logic        last_node  = 1'b1;
  logic [31:0] start_at   = '0;
  logic [31:0] node_at    = '0;
  logic        trip_live  = 1'b0;
  logic [15:0] node_total = '0;
  zone_t       zone_now   = ZONE_CLEAR;
  logic        brake_now  = 1'b0;

  report_t     pending_reports[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // random request generator state
  logic [31:0] clock_ms  = 32'd5000;
  logic        gen_start = 1'b1;
  logic        gen_node  = 1'b1;

  function automatic int unsigned echo_cm(logic [13:0] us);
    int unsigned d;
    if (us == 0) return 400;
    d = (32'(us) * 17) / 1000;
    return (d > 400) ? 400 : d;
  endfunction

  function automatic int unsigned tilt(logic signed [15:0] a);
    int v;
    v = a;
    return (v < 0) ? -v : v;
  endfunction

  function automatic int unsigned swerve(int unsigned d);
    int unsigned c;
    c = (d < 5) ? 5 : ((d > 200) ? 200 : d);
    return ((200 - c) * 90) / 195;
  endfunction

  function automatic report_t steer_outcome(tick_t t);
    report_t     r;
    int unsigned dl, dc, dr, pot_max, dev;
    r.node_event = 1'b0;
    r.trip_end   = END_NONE;
    r.angle      = 8'd90;
    r.duty       = 8'd0;
    dev          = 0;
    if (last_start && !t.start_level && (t.now_ms - start_at) > 32'(debounce_lim)) begin
      start_at = t.now_ms;
      if (!trip_live) begin
        trip_live  = 1'b1;
        node_total = '0;
      end else begin
        trip_live  = 1'b0;
        r.trip_end = END_BUTTON;
      end
      zone_now  = ZONE_CLEAR;
      brake_now = 1'b0;
    end
    last_start = t.start_level;
    if (!trip_live) begin
      last_node = t.node_level;
    end else begin
      if (last_node && !t.node_level && (t.now_ms - node_at) > 32'(debounce_lim)) begin
        node_at = t.now_ms;
        if (node_total != 16'hFFFF) node_total++;
        r.node_event = 1'b1;
      end
      last_node = t.node_level;
      if (imu_on && (tilt(t.accel_x) > fall_lim || tilt(t.accel_y) > fall_lim)) begin
        trip_live  = 1'b0;
        r.trip_end = END_FALL;
        zone_now   = ZONE_CLEAR;
        brake_now  = 1'b0;
      end else begin
        dl      = echo_cm(t.echo_left);
        dc      = echo_cm(t.echo_centre);
        dr      = echo_cm(t.echo_right);
        pot_max = (32'(t.pot_raw) * 255) / 4095;
        if (dc < 200) begin
          if (zone_now != ZONE_CENTRE) begin
            zone_now  = ZONE_CENTRE;
            brake_now = 1'b0;
          end
          if (dc < brake_cm) brake_now = 1'b1;
        end else if (dl < 200) begin
          dev       = swerve(dl);
          r.angle   = 8'(90 + dev);
          zone_now  = ZONE_LEFT;
          brake_now = 1'b0;
        end else if (dr < 200) begin
          dev       = swerve(dr);
          r.angle   = 8'(90 - dev);
          zone_now  = ZONE_RIGHT;
          brake_now = 1'b0;
        end else begin
          zone_now  = ZONE_CLEAR;
          brake_now = 1'b0;
        end
        r.duty = 8'((dev * pot_max) / 90);
      end
    end
    r.trip_on    = trip_live;
    r.nodes_seen = node_total;
    r.zone       = zone_now;
    r.brake      = brake_now;
    return r;
  endfunction

  function automatic tick_t tk(logic [31:0] now, bit st, bit nd, int ax, int ay,
                               int el, int ec, int er, int pot);
    tick_t t;
    t.now_ms      = now;
    t.start_level = st;
    t.node_level  = nd;
    t.accel_x     = 16'(ax);
    t.accel_y     = 16'(ay);
    t.echo_left   = 14'(el);
    t.echo_centre = 14'(ec);
    t.echo_right  = 14'(er);
    t.pot_raw     = 12'(pot);
    return t;
  endfunction

  function automatic report_t res(bit trip, int nodes, bit ev, trip_end_t e, zone_t z,
                                  bit brake, int angle, int duty);
    report_t r;
    r.trip_on    = trip;
    r.nodes_seen = 16'(nodes);
    r.node_event = ev;
    r.trip_end   = e;
    r.zone       = z;
    r.brake      = brake;
    r.angle      = 8'(angle);
    r.duty       = 8'(duty);
    return r;
  endfunction

  function automatic string show(report_t r);
    return $sformatf("trip=%0d nodes=%0d ev=%0d end=%0d zone=%0d brake=%0d angle=%0d duty=%0d",
                     r.trip_on, r.nodes_seen, r.node_event, r.trip_end, r.zone, r.brake,
                     r.angle, r.duty);
  endfunction

  function automatic logic [13:0] pick_echo(int unsigned zero_pct, int unsigned far_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return '0;
    if (r < zero_pct + far_pct) return 14'($urandom_range(11765, 12000));
    return 14'($urandom_range(1, 12000));
  endfunction

  // mostly plausible ticks: steady time, short presses, modest tilt
  task automatic roll_tick(output tick_t t);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 88) clock_ms += $urandom_range(1, 150);
    else if (r < 95) clock_ms += $urandom_range(151, 2000);
    else if (r < 98) clock_ms += $urandom_range(60000, 70000);
    else clock_ms = $urandom;
    t.now_ms = clock_ms;
    if (gen_start) gen_start = ($urandom_range(0, 99) >= 3);
    else gen_start = ($urandom_range(0, 99) < 70);
    if (gen_node) gen_node = ($urandom_range(0, 99) >= 35);
    else gen_node = ($urandom_range(0, 99) < 60);
    t.start_level = gen_start;
    t.node_level  = gen_node;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      t.accel_x = '0;
      t.accel_y = '0;
    end else if (r < 96) begin
      t.accel_x = 16'($urandom_range(0, 6000)) - 16'd3000;
      t.accel_y = 16'($urandom_range(0, 6000)) - 16'd3000;
    end else begin
      t.accel_x = 16'($urandom);
      t.accel_y = 16'($urandom);
    end
    t.echo_centre = pick_echo(30, 20);
    t.echo_left   = pick_echo(25, 25);
    t.echo_right  = pick_echo(10, 10);
    r = $urandom_range(0, 99);
    t.pot_raw = (r < 10) ? 12'd0 : ((r < 20) ? 12'd4095 : 12'($urandom_range(0, 4095)));
  endtask

  // entered and left at a falling edge
  task automatic send_tick(tick_t t, bit fixed, report_t want);
    report_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {t.pot_raw, t.echo_right, t.echo_centre, t.echo_left, t.accel_y, t.accel_x,
                 t.node_level, t.start_level, t.now_ms};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = steer_outcome(t);
    pending_reports.push_back(fixed ? want : predicted);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic settle();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, int unsigned value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = 16'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_DEBOUNCE:   debounce_lim = 16'(value);
      CFG_FALL_THR:   fall_lim     = 15'(value);
      CFG_IMU_EN:     imu_on       = value[0];
      CFG_BRAKE_DIST: brake_cm     = 9'(value);
      default: ;
    endcase
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    report_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.trip_on    = out_tdata[0];
      got.nodes_seen = out_tdata[16:1];
      got.node_event = out_tdata[17];
      got.trip_end   = trip_end_t'(out_tdata[19:18]);
      got.zone       = zone_t'(out_tdata[21:20]);
      got.brake      = out_tdata[22];
      got.angle      = out_tdata[30:23];
      got.duty       = out_tdata[38:31];
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", show(got));
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %s\n          actual   %s", show(want), show(got));
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    tick_t       t;
    int unsigned cfg_vals[4];
    plan_row_t   plan[26];

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_DEBOUNCE;
    cfg_wdata = '0;
    send_idle_pct = 6;
    recv_idle_pct = 65;

    plan[0]  = '{tk(1000, 1, 1, 0, 0, 0, 0, 0, 0), 1,
                 res(0, 0, 0, END_NONE, ZONE_CLEAR, 0, 90, 0)};
    plan[1]  = '{tk(1100, 0, 1, 0, 0, 0, 0, 0, 4095), 1,
                 res(1, 0, 0, END_NONE, ZONE_CLEAR, 0, 90, 0)};
    // hardest left and right swerve at full pot
    plan[2]  = '{tk(1200, 1, 0, 0, 0, 1, 12000, 0, 4095), 1,
                 res(1, 1, 1, END_NONE, ZONE_LEFT, 0, 180, 255)};
    plan[3]  = '{tk(1250, 1, 1, 100, -100, 0, 0, 1, 4095), 1,
                 res(1, 1, 0, END_NONE, ZONE_RIGHT, 0, 0, 255)};
    // node press inside the debounce window, then sticky brake
    plan[4]  = '{tk(1300, 1, 0, 0, 0, 0, 5000, 0, 1000), 1,
                 res(1, 1, 0, END_NONE, ZONE_CENTRE, 1, 90, 0)};
    plan[5]  = '{tk(1310, 1, 1, 0, 0, 0, 6000, 0, 1000), 1,
                 res(1, 1, 0, END_NONE, ZONE_CENTRE, 1, 90, 0)};
    plan[6]  = '{tk(1600, 1, 0, 0, 0, 11706, 11765, 0, 4095), 1,
                 res(1, 2, 1, END_NONE, ZONE_LEFT, 0, 90, 0)};
    plan[7]  = '{tk(1700, 1, 1, -32768, 0, 0, 0, 0, 4095), 1,
                 res(0, 2, 0, END_FALL, ZONE_CLEAR, 0, 90, 0)};
    plan[8]  = '{tk(1800, 1, 0, 32767, -32768, 1, 1, 1, 4095), 1,
                 res(0, 2, 0, END_NONE, ZONE_CLEAR, 0, 90, 0)};
    // tilt exactly at the threshold, then one above
    plan[9]  = '{tk(1900, 0, 1, 0, 6683, 0, 1, 0, 0), 1,
                 res(1, 0, 0, END_NONE, ZONE_CENTRE, 1, 90, 0)};
    plan[10] = '{tk(2000, 1, 1, 0, 6684, 0, 1, 0, 0), 1,
                 res(0, 0, 0, END_FALL, ZONE_CLEAR, 0, 90, 0)};
    plan[11] = '{tk(2100, 0, 1, 0, 0, 0, 0, 0, 0), 1,
                 res(0, 0, 0, END_NONE, ZONE_CLEAR, 0, 90, 0)};
    plan[12] = '{tk(2500, 1, 1, 0, 0, 0, 0, 0, 0), 1,
                 res(0, 0, 0, END_NONE, ZONE_CLEAR, 0, 90, 0)};
    plan[13] = '{tk(2600, 0, 1, 0, 0, 0, 0, 0, 0), 1,
                 res(1, 0, 0, END_NONE, ZONE_CLEAR, 0, 90, 0)};
    plan[14] = '{tk(2700, 1, 1, 1000, -1000, 3000, 0, 0, 2048), 0, '0};
    plan[15] = '{tk(2800, 1, 0, -6683, 6683, 0, 0, 9000, 3000), 0, '0};
    plan[16] = '{tk(2900, 1, 1, 0, 0, 5000, 5880, 7000, 4095), 0, '0};
    plan[17] = '{tk(3000, 0, 1, 0, 0, 0, 0, 0, 0), 1,
                 res(0, 1, 0, END_BUTTON, ZONE_CLEAR, 0, 90, 0)};
    // millisecond counter wrap
    plan[18] = '{tk(32'hFFFF_FE00, 1, 1, 0, 0, 0, 0, 0, 0), 1,
                 res(0, 1, 0, END_NONE, ZONE_CLEAR, 0, 90, 0)};
    plan[19] = '{tk(32'hFFFF_FF00, 0, 1, 0, 0, 0, 0, 0, 0), 1,
                 res(1, 0, 0, END_NONE, ZONE_CLEAR, 0, 90, 0)};
    plan[20] = '{tk(32'hFFFF_FF80, 1, 0, 0, 0, 2000, 0, 0, 4095), 0, '0};
    plan[21] = '{tk(32'h0000_0050, 0, 1, 0, 0, 0, 0, 0, 0), 1,
                 res(0, 1, 0, END_BUTTON, ZONE_CLEAR, 0, 90, 0)};
    plan[22] = '{tk(32'h0000_0060, 1, 1, 0, 0, 0, 0, 0, 0), 1,
                 res(0, 1, 0, END_NONE, ZONE_CLEAR, 0, 90, 0)};
    // press spacing equal to the debounce time is rejected
    plan[23] = '{tk(32'h0000_017C, 0, 1, 0, 0, 0, 0, 0, 0), 1,
                 res(0, 1, 0, END_NONE, ZONE_CLEAR, 0, 90, 0)};
    plan[24] = '{tk(32'h0000_017D, 1, 1, 0, 0, 0, 0, 0, 0), 1,
                 res(0, 1, 0, END_NONE, ZONE_CLEAR, 0, 90, 0)};
    plan[25] = '{tk(32'h0000_017E, 0, 1, 0, 0, 0, 0, 0, 0), 1,
                 res(1, 0, 0, END_NONE, ZONE_CLEAR, 0, 90, 0)};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) send_tick(plan[i].t, plan[i].fixed, plan[i].r);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: cfg_vals = '{300, 6683, 1, 100};
        1: cfg_vals = '{0, 0, 1, 0};
        2: cfg_vals = '{65535, 32767, 1, 400};
        3: cfg_vals = '{$urandom_range(0, 1000), $urandom_range(0, 32767), 0,
                        $urandom_range(0, 400)};
        4: cfg_vals = '{$urandom_range(0, 600), $urandom_range(3000, 32767),
                        $urandom_range(0, 1), $urandom_range(0, 400)};
        default: cfg_vals = '{150, 16384, 1, 200};
      endcase
      for (int k = 0; k < 4; k++) write_reg(cfg_index_t'(k), cfg_vals[k]);
      send_idle_pct = (ph < 2) ? 6 : ((ph < 4) ? 65 : 0);
      recv_idle_pct = (ph < 2) ? 65 : ((ph < 4) ? 6 : 0);
      repeat (217) begin
        roll_tick(t);
        send_tick(t, 0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
